// ----- design/vbmm_pkg.sv -----
// Shared types, constants and helpers for the volume block min/max unit.
// Depends on nothing; every other file in this folder imports it.
`timescale 1ns / 1ps

package vbmm_pkg;

    localparam int DIM_W      = 11;
    localparam int PITCH_W    = 7;
    localparam int FMT_W      = 2;
    localparam int BLK_W      = 11;
    localparam int VAL_W      = 32;
    localparam int IDX_W      = 18;
    localparam int OUT_DATA_W = 88;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;

    localparam int DEF_MAX_DIM      = 1024;
    localparam int DEF_MAX_BLOCKS_X = 64;
    localparam int DEF_MAX_BLOCKS_Y = 64;
    localparam int DEF_MAX_BLOCKS_Z = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_VOL_WIDTH    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VOL_HEIGHT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VOL_DEPTH    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PITCH_X      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PITCH_Y      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PITCH_Z      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_VOXEL_FORMAT = 3'd6;

    localparam logic [FMT_W-1:0] FMT_U8  = 2'd0;
    localparam logic [FMT_W-1:0] FMT_U16 = 2'd1;
    localparam logic [FMT_W-1:0] FMT_F32 = 2'd2;

    localparam logic [DIM_W-1:0]   RST_DIM   = 11'd1;
    localparam logic [PITCH_W-1:0] RST_PITCH = 7'd8;

    // Blocks touched along one axis by the current coordinate.
    typedef struct packed {
        logic             two;
        logic [BLK_W-1:0] q0;
        logic [BLK_W-1:0] q1;
        logic             f0;
        logic             f1;
        logic             d0;
        logic             d1;
    } axis_hit_t;

    typedef struct packed {
        axis_hit_t        hit;
        logic [BLK_W-1:0] nb;
        logic             ok;
        logic             last;
        logic             oor;
        logic             busy;
    } axis_stat_t;

    typedef struct packed {
        logic zero;
        logic inc;
    } axis_ctl_t;

    function automatic logic [VAL_W-1:0] mask_value(input logic [VAL_W-1:0] v,
                                                    input logic [FMT_W-1:0] fmt);
        logic [VAL_W-1:0] m;
        m = v;
        if (fmt == FMT_U8) begin
            m = {24'd0, v[7:0]};
        end else if (fmt == FMT_U16) begin
            m = {16'd0, v[15:0]};
        end
        return m;
    endfunction

    // Maps float bits onto an unsigned order for FMT_F32, other formats pass unchanged; -0 folds onto +0.
    function automatic logic [VAL_W-1:0] order_key(input logic [VAL_W-1:0] v,
                                                   input logic [FMT_W-1:0] fmt);
        logic [VAL_W-1:0] w;
        w = v;
        if (fmt == FMT_F32) begin
            if (w == 32'h8000_0000) begin
                w = '0;
            end
            w = w[31] ? ~w : (w | 32'h8000_0000);
        end
        return w;
    endfunction

endpackage

// ----- design/volume_block_min_max_unit.sv -----
// Top level of the volume block min/max unit: configuration registers, three
// axis trackers and the memory sequencer. Depends on vbmm_pkg, vbmm_axis, vbmm_seq.
//
// Usage: voxels enter on the s_ channel in raster order (x fastest), one per
// transfer, s_tdata = voxel_value, s_tuser = restart. Each voxel updates the
// accumulators of the one to eight widened blocks it falls into, one slab
// memory read-modify-write per block, reads and writes overlapped. After a
// transfer, s_tready stays low until the voxel's touched blocks are all
// written and any result it completed has moved to the result register.
// When a voxel completes a block, its index, minimum and maximum leave on the
// m_ channel from the result register once its last write is done;
// m_tlast marks the final block.
// The result register holds one result; while the receiver stalls it, the
// next voxel is still taken, and the sequencer waits only when a further
// result is ready. Under an invalid configuration voxels are taken and dropped.
// The configuration port is a plain write port; after reset and after every
// write, s_tready stays low while block counts and the current
// position's block and offset are re-derived by serial dividers. Reset clears
// position and handshake state; the accumulator memory is not cleared.
`timescale 1ns / 1ps

module volume_block_min_max_unit #(
    parameter int MAX_DIM      = vbmm_pkg::DEF_MAX_DIM,
    parameter int MAX_BLOCKS_X = vbmm_pkg::DEF_MAX_BLOCKS_X,
    parameter int MAX_BLOCKS_Y = vbmm_pkg::DEF_MAX_BLOCKS_Y,
    parameter int MAX_BLOCKS_Z = vbmm_pkg::DEF_MAX_BLOCKS_Z
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [vbmm_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  logic [vbmm_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [31:0]                     s_tdata,   // [31:0] voxel_value
    input  logic [0:0]                      s_tuser,   // [0] restart
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [17:0] block_index, [49:18] min_value, [81:50] max_value, [87:82] zero
    output logic [vbmm_pkg::OUT_DATA_W-1:0] m_tdata,
    output logic                            m_tlast    // last_block
);
    import vbmm_pkg::*;

    logic [DIM_W-1:0]   vol_width_reg, vol_height_reg, vol_depth_reg;
    logic [PITCH_W-1:0] pitch_x_reg, pitch_y_reg, pitch_z_reg;
    logic [FMT_W-1:0]   voxel_format_reg;

    axis_stat_t stat_x, stat_y, stat_z;
    axis_ctl_t  ctl, ctl_x, ctl_y, ctl_z;
    logic       cfg_ok;
    logic [IDX_W-1:0] block_index;
    logic [VAL_W-1:0] min_value, max_value;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vol_width_reg    <= RST_DIM;
            vol_height_reg   <= RST_DIM;
            vol_depth_reg    <= RST_DIM;
            pitch_x_reg      <= RST_PITCH;
            pitch_y_reg      <= RST_PITCH;
            pitch_z_reg      <= RST_PITCH;
            voxel_format_reg <= FMT_U8;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_VOL_WIDTH:    vol_width_reg    <= cfg_wdata;
                CFG_VOL_HEIGHT:   vol_height_reg   <= cfg_wdata;
                CFG_VOL_DEPTH:    vol_depth_reg    <= cfg_wdata;
                CFG_PITCH_X:      pitch_x_reg      <= cfg_wdata[PITCH_W-1:0];
                CFG_PITCH_Y:      pitch_y_reg      <= cfg_wdata[PITCH_W-1:0];
                CFG_PITCH_Z:      pitch_z_reg      <= cfg_wdata[PITCH_W-1:0];
                CFG_VOXEL_FORMAT: voxel_format_reg <= cfg_wdata[FMT_W-1:0];
                default: ;
            endcase
        end
    end

    // The position ripples like an odometer: y steps when x wraps, z when y wraps.
    assign ctl_x = ctl;
    assign ctl_y = '{zero: ctl.zero, inc: ctl.inc && stat_x.last};
    assign ctl_z = '{zero: ctl.zero, inc: ctl.inc && stat_x.last && stat_y.last};

    vbmm_axis #(.MAX_DIM(MAX_DIM), .MAX_BLOCKS(MAX_BLOCKS_X)) u_axis_x (
        .aclk(aclk), .aresetn(aresetn), .cfg_wr(cfg_wr_en), .dim(vol_width_reg),
        .pitch(pitch_x_reg), .ctl(ctl_x), .stat(stat_x)
    );

    vbmm_axis #(.MAX_DIM(MAX_DIM), .MAX_BLOCKS(MAX_BLOCKS_Y)) u_axis_y (
        .aclk(aclk), .aresetn(aresetn), .cfg_wr(cfg_wr_en), .dim(vol_height_reg),
        .pitch(pitch_y_reg), .ctl(ctl_y), .stat(stat_y)
    );

    vbmm_axis #(.MAX_DIM(MAX_DIM), .MAX_BLOCKS(MAX_BLOCKS_Z)) u_axis_z (
        .aclk(aclk), .aresetn(aresetn), .cfg_wr(cfg_wr_en), .dim(vol_depth_reg),
        .pitch(pitch_z_reg), .ctl(ctl_z), .stat(stat_z)
    );

    assign cfg_ok = (voxel_format_reg <= FMT_F32) && stat_x.ok && stat_y.ok && stat_z.ok;

    vbmm_seq #(.MAX_BLOCKS_X(MAX_BLOCKS_X), .MAX_BLOCKS_Y(MAX_BLOCKS_Y)) u_seq (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready),
        .voxel_value(s_tdata), .restart(s_tuser[0]),
        .cfg_ok(cfg_ok), .fmt(voxel_format_reg),
        .stat_x(stat_x), .stat_y(stat_y), .stat_z(stat_z), .ctl(ctl),
        .m_tvalid(m_tvalid), .m_tready(m_tready),
        .block_index(block_index), .min_value(min_value), .max_value(max_value),
        .last_block(m_tlast)
    );

    assign m_tdata = {6'd0, max_value, min_value, block_index};

endmodule

// ----- design/vbmm_div.sv -----
// Restoring shift-subtract divider, one quotient bit per cycle.
// Depends on vbmm_pkg for the operand widths.
`timescale 1ns / 1ps

module vbmm_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [vbmm_pkg::DIM_W-1:0]  num,
    input  logic [vbmm_pkg::PITCH_W-1:0] den,
    output logic [vbmm_pkg::DIM_W-1:0]  quo,
    output logic [vbmm_pkg::PITCH_W-1:0] rem,
    output logic                        busy
);
    import vbmm_pkg::*;

    localparam int CNT_W = $clog2(DIM_W + 1);

    logic [CNT_W-1:0]   cnt_reg;
    logic [DIM_W-1:0]   num_reg;
    logic [DIM_W-1:0]   quo_reg;
    logic [PITCH_W-1:0] rem_reg;
    logic [PITCH_W-1:0] den_reg;
    logic [PITCH_W:0]   trial;
    logic               take;

    assign trial = {rem_reg, num_reg[DIM_W-1]};
    assign take  = trial >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (start) begin
            cnt_reg <= CNT_W'(DIM_W);
            num_reg <= num;
            den_reg <= den;
            rem_reg <= '0;
            quo_reg <= '0;
        end else if (cnt_reg != '0) begin
            cnt_reg <= cnt_reg - 1'b1;
            num_reg <= {num_reg[DIM_W-2:0], 1'b0};
            quo_reg <= {quo_reg[DIM_W-2:0], take};
            rem_reg <= take ? PITCH_W'(trial - {1'b0, den_reg}) : trial[PITCH_W-1:0];
        end
    end

    assign quo  = quo_reg;
    assign rem  = rem_reg;
    assign busy = cnt_reg != '0;

endmodule

// ----- design/vbmm_axis.sv -----
// One axis of the voxel position: position, block and offset counters,
// block count and the blocks a coordinate touches. Uses vbmm_div and vbmm_pkg.
`timescale 1ns / 1ps

module vbmm_axis #(
    parameter int MAX_DIM    = vbmm_pkg::DEF_MAX_DIM,
    parameter int MAX_BLOCKS = vbmm_pkg::DEF_MAX_BLOCKS_X
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr,
    input  logic [vbmm_pkg::DIM_W-1:0]   dim,
    input  logic [vbmm_pkg::PITCH_W-1:0] pitch,
    input  vbmm_pkg::axis_ctl_t          ctl,
    output vbmm_pkg::axis_stat_t         stat
);
    import vbmm_pkg::*;

    logic               start_reg;
    logic               run_reg;
    logic [DIM_W-1:0]   pos_reg;
    logic [BLK_W-1:0]   b_reg;
    logic [PITCH_W-1:0] r_reg;

    logic [DIM_W-1:0]   dim_quo, pos_quo;
    logic [PITCH_W-1:0] dim_rem, pos_rem;
    logic               dim_busy, pos_busy;
    logic [BLK_W-1:0]   nb;
    logic               last;
    axis_hit_t          hit;

    vbmm_div u_div_dim (
        .aclk(aclk), .aresetn(aresetn), .start(start_reg), .num(dim), .den(pitch),
        .quo(dim_quo), .rem(dim_rem), .busy(dim_busy)
    );

    vbmm_div u_div_pos (
        .aclk(aclk), .aresetn(aresetn), .start(start_reg), .num(pos_reg), .den(pitch),
        .quo(pos_quo), .rem(pos_rem), .busy(pos_busy)
    );

    // A configuration write re-derives block and offset from the position.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg <= 1'b1;
            run_reg   <= 1'b0;
            pos_reg   <= '0;
            b_reg     <= '0;
            r_reg     <= '0;
        end else if (cfg_wr) begin
            start_reg <= 1'b1;
        end else if (start_reg) begin
            start_reg <= 1'b0;
            run_reg   <= 1'b1;
        end else if (run_reg) begin
            if (!pos_busy && !dim_busy) begin
                run_reg <= 1'b0;
                b_reg   <= BLK_W'(pos_quo);
                r_reg   <= pos_rem;
            end
        end else if (ctl.zero) begin
            pos_reg <= '0;
            b_reg   <= '0;
            r_reg   <= '0;
        end else if (ctl.inc) begin
            if (last) begin
                pos_reg <= '0;
                b_reg   <= '0;
                r_reg   <= '0;
            end else begin
                pos_reg <= pos_reg + 1'b1;
                if (r_reg + 1'b1 == pitch) begin
                    r_reg <= '0;
                    b_reg <= b_reg + 1'b1;
                end else begin
                    r_reg <= r_reg + 1'b1;
                end
            end
        end
    end

    assign nb   = BLK_W'(dim_quo) + BLK_W'(dim_rem != '0);
    assign last = ({1'b0, pos_reg} + 1'b1) == {1'b0, dim};

    // The widened block above starts on the last voxel of this block; the
    // block below ends on the first voxel of this one.
    always_comb begin
        hit = '0;
        if (r_reg == '0 && b_reg != '0) begin
            hit.two = 1'b1;
            hit.q0  = b_reg - 1'b1;
            hit.f0  = 1'b0;
            hit.d0  = 1'b1;
            hit.q1  = b_reg;
            hit.f1  = 1'b0;
            hit.d1  = (b_reg + 1'b1 == nb) && last;
        end else begin
            hit.q0 = b_reg;
            hit.f0 = (b_reg == '0) && (r_reg == '0);
            hit.d0 = (b_reg + 1'b1 == nb) && last;
            hit.q1 = b_reg + 1'b1;
            hit.f1 = 1'b1;
            hit.d1 = 1'b0;
            hit.two = (r_reg == pitch - 1'b1) && (b_reg + 1'b1 < nb);
        end
    end

    always_comb begin
        stat.hit  = hit;
        stat.nb   = nb;
        stat.last = last;
        stat.oor  = pos_reg >= dim;
        stat.busy = start_reg || run_reg;
        stat.ok   = (pitch >= PITCH_W'(2)) && (dim != '0) &&
                    ({2'b00, dim} <= 13'(MAX_DIM)) &&
                    ({1'b0, nb} <= 12'(MAX_BLOCKS)) &&
                    !((dim > DIM_W'(pitch)) && (dim_rem == PITCH_W'(1)));
    end

endmodule

// ----- design/vbmm_seq.sv -----
// Voxel sequencer: accepts voxels, walks the touched block accumulators with
// read-modify-write in the slab memory and holds the result register.
// Depends on vbmm_pkg.
`timescale 1ns / 1ps

module vbmm_seq #(
    parameter int MAX_BLOCKS_X = vbmm_pkg::DEF_MAX_BLOCKS_X,
    parameter int MAX_BLOCKS_Y = vbmm_pkg::DEF_MAX_BLOCKS_Y
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [vbmm_pkg::VAL_W-1:0]   voxel_value,
    input  logic                         restart,
    input  logic                         cfg_ok,
    input  logic [vbmm_pkg::FMT_W-1:0]   fmt,
    input  vbmm_pkg::axis_stat_t         stat_x,
    input  vbmm_pkg::axis_stat_t         stat_y,
    input  vbmm_pkg::axis_stat_t         stat_z,
    output vbmm_pkg::axis_ctl_t          ctl,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [vbmm_pkg::IDX_W-1:0]   block_index,
    output logic [vbmm_pkg::VAL_W-1:0]   min_value,
    output logic [vbmm_pkg::VAL_W-1:0]   max_value,
    output logic                         last_block
);
    import vbmm_pkg::*;

    localparam int SLAB   = MAX_BLOCKS_X * MAX_BLOCKS_Y;
    localparam int SLOTS  = 2 * SLAB;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int PROD_W = 2 * BLK_W;
    localparam int MUL_W  = IDX_W + BLK_W;

    typedef enum logic [1:0] {S_IDLE, S_LOAD, S_RUN, S_FINISH} state_t;

    state_t            state_reg;
    logic [VAL_W-1:0]  v_reg;
    axis_hit_t         hx_reg, hy_reg, hz_reg;
    logic              ix_reg, iy_reg, iz_reg;
    logic              more_reg;
    logic              pend_reg;
    logic [SLOT_W-1:0] pend_slot_reg;
    logic              pend_first_reg;
    logic              pend_done_reg;
    logic [IDX_W-1:0]  t_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [BLK_W-1:0]  nbx_reg;
    logic [BLK_W-1:0]  dxq_reg;
    logic              lastb_reg;
    logic              has_res_reg;
    logic [VAL_W-1:0]  res_lo_reg, res_hi_reg;
    logic              out_valid_reg;
    logic [IDX_W-1:0]  out_idx_reg;
    logic [VAL_W-1:0]  out_lo_reg, out_hi_reg;
    logic              out_last_reg;

    logic [63:0]       mem [SLOTS];
    logic [63:0]       mem_q_reg;

    logic              accept;
    logic [BLK_W-1:0]  qx, qy, qz;
    logic              c_first, c_done, c_end;
    logic [SLOT_W-1:0] slot;
    logic [BLK_W-1:0]  dxq, dyq, dzq;
    logic [PROD_W-1:0] t_full;
    logic [MUL_W-1:0]  idx_full;
    logic [VAL_W-1:0]  key_v, cur_lo, cur_hi, new_lo, new_hi;
    logic              out_free;
    logic              out_load;

    assign s_tready = (state_reg == S_IDLE) && !stat_x.busy && !stat_y.busy && !stat_z.busy;
    assign accept   = s_tvalid && s_tready;

    assign ctl.zero = accept && cfg_ok && (restart || stat_x.oor || stat_y.oor || stat_z.oor);
    assign ctl.inc  = state_reg == S_LOAD;

    // Current block combination, x fastest.
    always_comb begin
        qx      = ix_reg ? hx_reg.q1 : hx_reg.q0;
        qy      = iy_reg ? hy_reg.q1 : hy_reg.q0;
        qz      = iz_reg ? hz_reg.q1 : hz_reg.q0;
        c_first = (ix_reg ? hx_reg.f1 : hx_reg.f0) && (iy_reg ? hy_reg.f1 : hy_reg.f0) &&
                  (iz_reg ? hz_reg.f1 : hz_reg.f0);
        c_done  = (ix_reg ? hx_reg.d1 : hx_reg.d0) && (iy_reg ? hy_reg.d1 : hy_reg.d0) &&
                  (iz_reg ? hz_reg.d1 : hz_reg.d0);
        c_end   = (!hx_reg.two || ix_reg) && (!hy_reg.two || iy_reg) &&
                  (!hz_reg.two || iz_reg);
        slot    = SLOT_W'(qz[0]) * SLOT_W'(SLAB) + SLOT_W'(qy) * SLOT_W'(MAX_BLOCKS_X) +
                  SLOT_W'(qx);
    end

    // At most one combination completes; its index is formed in two multiplies.
    assign dxq      = stat_x.hit.d0 ? stat_x.hit.q0 : stat_x.hit.q1;
    assign dyq      = stat_y.hit.d0 ? stat_y.hit.q0 : stat_y.hit.q1;
    assign dzq      = stat_z.hit.d0 ? stat_z.hit.q0 : stat_z.hit.q1;
    assign t_full   = PROD_W'(dzq) * PROD_W'(stat_y.nb) + PROD_W'(dyq);
    assign idx_full = MUL_W'(t_reg) * MUL_W'(nbx_reg) + MUL_W'(dxq_reg);

    always_comb begin
        key_v  = order_key(v_reg, fmt);
        cur_lo = mem_q_reg[31:0];
        cur_hi = mem_q_reg[63:32];
        if (pend_first_reg) begin
            new_lo = v_reg;
            new_hi = v_reg;
        end else begin
            new_lo = (key_v < order_key(cur_lo, fmt)) ? v_reg : cur_lo;
            new_hi = (key_v > order_key(cur_hi, fmt)) ? v_reg : cur_hi;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_RUN && more_reg) begin
            mem_q_reg <= mem[slot];
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_RUN && pend_reg) begin
            mem[pend_slot_reg] <= {new_hi, new_lo};
        end
    end

    assign out_free = !out_valid_reg || m_tready;
    assign out_load = (state_reg == S_FINISH) && has_res_reg && out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            more_reg      <= 1'b0;
            pend_reg      <= 1'b0;
            has_res_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            ix_reg        <= 1'b0;
            iy_reg        <= 1'b0;
            iz_reg        <= 1'b0;
        end else begin
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (accept && cfg_ok) begin
                        v_reg       <= mask_value(voxel_value, fmt);
                        has_res_reg <= 1'b0;
                        state_reg   <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    hx_reg    <= stat_x.hit;
                    hy_reg    <= stat_y.hit;
                    hz_reg    <= stat_z.hit;
                    ix_reg    <= 1'b0;
                    iy_reg    <= 1'b0;
                    iz_reg    <= 1'b0;
                    more_reg  <= 1'b1;
                    pend_reg  <= 1'b0;
                    t_reg     <= t_full[IDX_W-1:0];
                    nbx_reg   <= stat_x.nb;
                    dxq_reg   <= dxq;
                    lastb_reg <= (dxq == stat_x.nb - 1'b1) && (dyq == stat_y.nb - 1'b1) &&
                                 (dzq == stat_z.nb - 1'b1);
                    state_reg <= S_RUN;
                end
                S_RUN: begin
                    idx_reg <= idx_full[IDX_W-1:0];
                    // Reads of the next entry overlap the write of the previous
                    // one; entries of one voxel are all distinct.
                    if (more_reg) begin
                        pend_reg       <= 1'b1;
                        pend_slot_reg  <= slot;
                        pend_first_reg <= c_first;
                        pend_done_reg  <= c_done;
                        if (c_end) begin
                            more_reg <= 1'b0;
                        end else if (hx_reg.two && !ix_reg) begin
                            ix_reg <= 1'b1;
                        end else if (hy_reg.two && !iy_reg) begin
                            ix_reg <= 1'b0;
                            iy_reg <= 1'b1;
                        end else begin
                            ix_reg <= 1'b0;
                            iy_reg <= 1'b0;
                            iz_reg <= 1'b1;
                        end
                    end else begin
                        pend_reg <= 1'b0;
                    end
                    if (pend_reg && pend_done_reg) begin
                        has_res_reg <= 1'b1;
                        res_lo_reg  <= new_lo;
                        res_hi_reg  <= new_hi;
                    end
                    if (!more_reg && !pend_reg) begin
                        state_reg <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    if (!has_res_reg) begin
                        state_reg <= S_IDLE;
                    end else if (out_free) begin
                        out_idx_reg  <= idx_reg;
                        out_lo_reg   <= res_lo_reg;
                        out_hi_reg   <= res_hi_reg;
                        out_last_reg <= lastb_reg;
                        has_res_reg  <= 1'b0;
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid    = out_valid_reg;
    assign block_index = out_idx_reg;
    assign min_value   = out_lo_reg;
    assign max_value   = out_hi_reg;
    assign last_block  = out_last_reg;

endmodule

// ----- design/vbmm_checker.sv -----
// Port-level checks for the volume block min/max unit, bound to the top level.
// Depends on vbmm_pkg.
`timescale 1ns / 1ps

module vbmm_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            cfg_wr_en,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [vbmm_pkg::OUT_DATA_W-1:0] m_tdata,
    input logic                            m_tlast
);
    import vbmm_pkg::*;

    // A stalled result keeps its contents.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[OUT_DATA_W-1:82] == '0)
        else $error("padding bits of result not zero");

    // Block geometry is re-derived after any write, so no voxel is taken then.
    a_cfg: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_wr_en |=> !s_tready)
        else $error("voxel taken right after a configuration write");

    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && !s_tready)
        else $error("handshake active right after reset");

endmodule

bind volume_block_min_max_unit vbmm_checker u_vbmm_checker (.*);

// ----- tb/sv/volume_block_min_max_unit_test.sv -----
// Self-checking testbench for volume_block_min_max_unit: streams whole volumes under many
// block layouts and formats and checks every block range against an in-bench predictor.
// Depends on vbmm_pkg and the unit's RTL.
`timescale 1ns / 1ps

module volume_block_min_max_unit_test;
    import vbmm_pkg::*;

    typedef struct {
        logic [31:0] value;
        logic        restart;
    } voxel_t;

    typedef struct {
        logic [IDX_W-1:0] index;
        logic [31:0]      lo;
        logic [31:0]      hi;
        logic             last;
    } block_range_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [31:0]           s_tdata = '0;
    logic [0:0]            s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tlast;

    volume_block_min_max_unit uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Predictor state: configuration mirror, raster position and the slab store.
    int unsigned vol_w = 1, vol_h = 1, vol_d = 1;
    int unsigned pit_x = 8, pit_y = 8, pit_z = 8;
    int unsigned fmt = 0;
    int unsigned pos_x = 0, pos_y = 0, pos_z = 0;
    logic [63:0] slab [0:2*64*64-1];

    voxel_t       voxel_q[$];
    block_range_t range_q[$];
    int           errors = 0;
    int           voxels_taken = 0;
    int           ranges_seen = 0;
    int           voxels_queued = 0;
    int           layouts = 0;
    int unsigned  stall_left = 0;
    bit           stall_go = 1'b0;
    int           idle_snd, idle_rcv;

    function automatic int unsigned block_count(int unsigned dim, int unsigned p);
        return dim / p + ((dim % p) != 0 ? 1 : 0);
    endfunction

    function automatic bit axis_valid(int unsigned dim, int unsigned p);
        if (p < 2 || dim < 1 || dim > DEF_MAX_DIM) return 1'b0;
        if (block_count(dim, p) > 64) return 1'b0;
        if (dim > p && dim % p == 1) return 1'b0;
        return 1'b1;
    endfunction

    function automatic bit layout_valid();
        return fmt <= 2 && axis_valid(vol_w, pit_x) && axis_valid(vol_h, pit_y)
               && axis_valid(vol_d, pit_z);
    endfunction

    // Blocks whose widened range holds coordinate c along one axis, at most two.
    function automatic int axis_touch(input int unsigned c, dim, p, nb,
                                      output int unsigned bk[2], output bit fs[2],
                                      output bit dn[2]);
        int unsigned b, r, q, st, en;
        int unsigned cand[3];
        int n;
        b = c / p;
        r = c % p;
        n = 0;
        if (r == 0 && b > 0) begin cand[n] = b - 1; n++; end
        cand[n] = b; n++;
        if (r == p - 1 && b + 1 < nb) begin cand[n] = b + 1; n++; end
        if (n > 2) n = 2;
        for (int k = 0; k < n; k++) begin
            q = cand[k];
            st = q > 0 ? q * p - 1 : 0;
            en = (q + 1 < nb) ? (q + 1) * p : dim - 1;
            bk[k] = q;
            fs[k] = (c == st);
            dn[k] = (c == en);
        end
        return n;
    endfunction

    function automatic logic [31:0] sort_key(logic [31:0] v);
        logic [31:0] w;
        w = v;
        if (fmt != 2) return w;
        if (w == 32'h8000_0000) w = '0;
        return w[31] ? ~w : (w | 32'h8000_0000);
    endfunction

    function automatic bit fold_voxel(input logic [31:0] raw, input bit rst,
                                      output block_range_t res);
        logic [31:0] v, lo, hi;
        int unsigned nbx, nby, nbz, slot, idx;
        int unsigned bx[2], by[2], bz[2];
        bit fx[2], fy[2], fz[2], dx[2], dy[2], dz[2];
        int nx, ny, nz;
        bit got;
        got = 1'b0;
        if (!layout_valid()) return 1'b0;
        v = raw;
        if (fmt == 0) v = {24'd0, raw[7:0]};
        else if (fmt == 1) v = {16'd0, raw[15:0]};
        if (rst || pos_x >= vol_w || pos_y >= vol_h || pos_z >= vol_d) begin
            pos_x = 0; pos_y = 0; pos_z = 0;
        end
        nbx = block_count(vol_w, pit_x);
        nby = block_count(vol_h, pit_y);
        nbz = block_count(vol_d, pit_z);
        nx = axis_touch(pos_x, vol_w, pit_x, nbx, bx, fx, dx);
        ny = axis_touch(pos_y, vol_h, pit_y, nby, by, fy, dy);
        nz = axis_touch(pos_z, vol_d, pit_z, nbz, bz, fz, dz);
        for (int iz = 0; iz < nz; iz++)
            for (int iy = 0; iy < ny; iy++)
                for (int ix = 0; ix < nx; ix++) begin
                    slot = (bz[iz] & 1) * 4096 + by[iy] * 64 + bx[ix];
                    if (fx[ix] && fy[iy] && fz[iz]) begin
                        lo = v;
                        hi = v;
                    end else begin
                        lo = slab[slot][31:0];
                        hi = slab[slot][63:32];
                        if (sort_key(v) < sort_key(lo)) lo = v;
                        if (sort_key(v) > sort_key(hi)) hi = v;
                    end
                    slab[slot] = {hi, lo};
                    if (dx[ix] && dy[iy] && dz[iz] && !got) begin
                        idx = (bz[iz] * nby + by[iy]) * nbx + bx[ix];
                        res.index = idx[IDX_W-1:0];
                        res.lo = lo;
                        res.hi = hi;
                        res.last = (idx == nbx * nby * nbz - 1);
                        got = 1'b1;
                    end
                end
        pos_x++;
        if (pos_x >= vol_w) begin
            pos_x = 0;
            pos_y++;
            if (pos_y >= vol_h) begin
                pos_y = 0;
                pos_z++;
                if (pos_z >= vol_d) pos_z = 0;
            end
        end
        return got;
    endfunction

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        errors++;
        $display("MISMATCH %s at result %0d: got %h, expected %h", field, ranges_seen, got,
                 want);
    endtask

    // Idle rates: the receiver idles more for the first 300 voxels taken, the sender for the next 300, then none.
    always_comb begin
        if (voxels_taken < 300) begin
            idle_snd = 36; idle_rcv = 47;
        end else if (voxels_taken < 600) begin
            idle_snd = 47; idle_rcv = 36;
        end else begin
            idle_snd = 0; idle_rcv = 0;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (voxel_q.size() > 0 && $urandom_range(99) >= idle_snd) begin
                s_tdata  <= voxel_q[0].value;
                s_tuser  <= voxel_q[0].restart;
                s_tvalid <= 1'b1;
                void'(voxel_q.pop_front());
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Long receiver hold-off, counted here so the block backs up into its input.
    always @(posedge aclk) begin
        if (stall_go) stall_left <= 400;
        else if (stall_left != 0) stall_left <= stall_left - 1;
    end

    always @(posedge aclk) begin
        if (!aresetn) m_tready <= 1'b0;
        else m_tready <= (stall_left == 0) && ($urandom_range(99) >= idle_rcv);
    end

    always @(posedge aclk) begin
        block_range_t res, want;
        if (aresetn && s_tvalid && s_tready) begin
            voxels_taken++;
            if (fold_voxel(s_tdata, s_tuser[0], res)) range_q = {range_q, res};
        end
        if (aresetn && m_tvalid && m_tready) begin
            ranges_seen++;
            if (range_q.size() == 0) begin
                errors++;
                $display("MISMATCH unexpected result, block %0d", m_tdata[17:0]);
            end else begin
                want = range_q.pop_front();
                if (m_tdata[17:0] !== want.index)
                    report_mismatch("block_index", 32'(m_tdata[17:0]), 32'(want.index));
                if (m_tdata[49:18] !== want.lo) report_mismatch("min_value", m_tdata[49:18], want.lo);
                if (m_tdata[81:50] !== want.hi) report_mismatch("max_value", m_tdata[81:50], want.hi);
                if (m_tdata[87:82] !== 6'd0)
                    report_mismatch("padding", 32'(m_tdata[87:82]), 32'd0);
                if (m_tlast !== want.last)
                    report_mismatch("last_block", 32'(m_tlast), 32'(want.last));
            end
        end
    end

    task automatic drain();
        wait (voxel_q.size() == 0 && !s_tvalid && range_q.size() == 0);
        repeat (24) @(posedge aclk);
    endtask

    task automatic set_layout(int unsigned w, h, d, px, py, pz, f);
        logic [CFG_DATA_W-1:0] vals[7];
        drain();
        vals = '{CFG_DATA_W'(w), CFG_DATA_W'(h), CFG_DATA_W'(d), CFG_DATA_W'(px),
                 CFG_DATA_W'(py), CFG_DATA_W'(pz), CFG_DATA_W'(f)};
        for (int i = 0; i < 7; i++) begin
            @(posedge aclk);
            cfg_wr_en <= 1'b1;
            cfg_addr  <= CFG_IDX_W'(i);
            cfg_wdata <= vals[i];
        end
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        vol_w = w & 11'h7FF; vol_h = h & 11'h7FF; vol_d = d & 11'h7FF;
        pit_x = px & 7'h7F; pit_y = py & 7'h7F; pit_z = pz & 7'h7F;
        fmt = f & 2'h3;
        layouts++;
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(11))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'h7F7F_FFFF;
            4: return 32'hFF7F_FFFF;
            5: return 32'h7F80_0000;
            6: return 32'hFF80_0000;
            7: return {1'($urandom_range(1)), 31'($urandom_range(255) << 23)};
            default: return $urandom;
        endcase
    endfunction

    task automatic push_voxels(int n, bit first_restart);
        voxel_t vx;
        for (int i = 0; i < n; i++) begin
            vx.value = pick_value();
            vx.restart = (i == 0) ? first_restart : 1'b0;
            voxel_q = {voxel_q, vx};
            if (layout_valid()) voxels_queued++;
        end
    endtask

    initial begin
        int unsigned w, h, d, px, py, pz, f, n;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset layout: one voxel volume, every voxel closes block 0.
        push_voxels(3, 1'b0);
        push_voxels(2, 1'b1);
        // Float order with signed zeros, infinities and the largest finite values.
        set_layout(4, 2, 2, 2, 2, 2, FMT_F32);
        push_voxels(16, 1'b1);
        // Rejected layouts: voxels are dropped and nothing comes out.
        set_layout(4, 4, 4, 2, 2, 2, 3);
        push_voxels(2, 1'b1);
        set_layout(5, 4, 4, 2, 2, 2, FMT_U8);
        push_voxels(2, 1'b1);
        set_layout(4, 4, 4, 1, 2, 2, FMT_U8);
        push_voxels(1, 1'b1);
        set_layout(0, 4, 4, 2, 2, 2, FMT_U8);
        push_voxels(1, 1'b1);
        set_layout(1025, 1, 1, 64, 2, 2, FMT_U8);
        push_voxels(1, 1'b1);
        set_layout(130, 1, 1, 2, 2, 2, FMT_U8);
        push_voxels(1, 1'b1);
        // A shrunken depth leaves the position outside: the next voxel restarts.
        set_layout(4, 4, 4, 2, 2, 2, FMT_U16);
        push_voxels(40, 1'b1);
        set_layout(4, 4, 2, 2, 2, 2, FMT_U16);
        push_voxels(32, 1'b0);
        // The most blocks along one edge, with the receiver held off for a long
        // stretch while voxels keep coming.
        set_layout(128, 1, 1, 2, 2, 2, FMT_U8);
        push_voxels(128, 1'b1);
        @(posedge aclk);
        stall_go <= 1'b1;
        @(posedge aclk);
        stall_go <= 1'b0;
        // Pitches of 64 on every axis; the sender pauses until every result is out.
        set_layout(66, 2, 2, 64, 64, 64, FMT_U16);
        push_voxels(66 * 2 * 2 / 8, 1'b1);
        wait (voxel_q.size() == 0 && range_q.size() == 0);
        push_voxels(66 * 2 * 2, 1'b1);

        while (voxels_queued < 840) begin
            w = $urandom_range(1, 9); h = $urandom_range(1, 6); d = $urandom_range(1, 5);
            px = $urandom_range(2, 5); py = $urandom_range(2, 5); pz = $urandom_range(2, 5);
            f = $urandom_range(2);
            if ($urandom_range(9) == 0) f = 3;
            set_layout(w, h, d, px, py, pz, f);
            n = w * h * d;
            if (!layout_valid()) begin
                push_voxels(3, 1'b1);
            end else begin
                if ($urandom_range(7) == 0) push_voxels($urandom_range(1, n), 1'b1);
                push_voxels(n, 1'b1);
                push_voxels(n, 1'($urandom_range(1)));
            end
        end

        drain();
        repeat (40) @(posedge aclk);
        $display("Streamed %0d voxels over %0d block layouts in three formats.", voxels_taken,
                 layouts);
        $display("Checked %0d block ranges, %0d mismatches.", ranges_seen, errors);
        if (errors == 0 && range_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #40_000_000;
        $display("Timeout waiting for transfers.");
        $display("Verification failed");
        $finish;
    end

endmodule
